// ===== hdl/sensor_frame_deframer_crc8_defines.svh =====
// Assertion macros shared by the deframer's checking code.
`ifndef SENSOR_FRAME_DEFRAMER_CRC8_DEFINES_SVH
`define SENSOR_FRAME_DEFRAMER_CRC8_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sfd_pkg.sv =====
package sfd_pkg;

  // buffer index / fill count, holds 0..72
  typedef logic [6:0] idx_t;

  localparam idx_t FRAME_BYTES = 7'd72;
  localparam idx_t FRAME_LAST  = 7'd71;
  localparam idx_t LEN_POS     = 7'd4;
  localparam idx_t CRC_POS     = 7'd69;
  localparam idx_t TAIL0_POS   = 7'd70;
  localparam idx_t FIELD_FIRST = 7'd5;
  localparam idx_t FIELD_END   = 7'd68;

  localparam logic [7:0] HDR0     = 8'hA5;
  localparam logic [7:0] HDR1     = 8'h5A;
  localparam logic [7:0] TAIL0    = 8'h0D;
  localparam logic [7:0] TAIL1    = 8'h0A;
  localparam logic [7:0] LEN_VAL  = 8'd64;
  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [4:0] FID_COUNT  = 5'd0;
  localparam logic [4:0] FID_TSTAMP = 5'd1;
  localparam logic [4:0] FID_FLOAT0 = 5'd2;
  localparam logic [4:0] FID_TEMP   = 5'd15;
  localparam logic [4:0] FID_STATUS = 5'd16;

  // byte queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } front_state_t;

  // where a frame byte lands in the result run
  typedef struct packed {
    logic [4:0] fid;
    logic [2:0] pos;   // byte lane inside the field, little endian
    logic       fend;  // last byte of its field
  } byte_tag_t;

  typedef struct packed {
    logic [7:0] data;
    byte_tag_t  tag;
  } q_entry_t;

  // one CRC-8 byte update, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // circular buffer wrap of head plus offset, sum below twice the depth
  function automatic idx_t wrap_idx(input logic [7:0] a);
    if (a >= {1'b0, FRAME_BYTES}) return 7'(a - {1'b0, FRAME_BYTES});
    else                          return 7'(a);
  endfunction

  // field layout of a frame byte in the readout range
  function automatic byte_tag_t field_tag(input idx_t idx);
    byte_tag_t t;
    idx_t      rel;
    rel = 7'(idx - 7'd14);
    t.fid  = FID_STATUS;
    t.pos  = 3'd0;
    t.fend = 1'b1;
    if (idx <= 7'd5) begin
      t.fid = FID_COUNT;
    end else if (idx <= 7'd13) begin
      t.fid  = FID_TSTAMP;
      t.pos  = 3'(idx - 7'd6);
      t.fend = (idx == 7'd13);
    end else if (idx <= 7'd65) begin
      t.fid  = FID_FLOAT0 + rel[6:2];
      t.pos  = {1'b0, rel[1:0]};
      t.fend = (rel[1:0] == 2'd3);
    end else if (idx <= 7'd67) begin
      t.fid  = FID_TEMP;
      t.pos  = 3'(idx - 7'd66);
      t.fend = (idx == 7'd67);
    end
    return t;
  endfunction

endpackage

// ===== hdl/sfd_queue.sv =====
module sfd_queue
  import sfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  q_entry_t           push_entry,
  input  logic               pop,
  output q_entry_t           head_entry,
  output logic               empty,
  output logic [Q_CNT_W-1:0] used
);

  q_entry_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   used_r, used_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    used_nxt   = used_r;
    if (push) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = rd_ptr_r + 1'b1;
    if (push && !pop)      used_nxt = used_r + 1'b1;
    else if (pop && !push) used_nxt = used_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      used_r   <= used_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  assign head_entry = slot_r[rd_ptr_r];
  assign empty      = (used_r == '0);
  assign used       = used_r;

endmodule

// ===== hdl/sfd_front.sv =====
module sfd_front
  import sfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] rx_byte
  input  logic [Q_CNT_W-1:0] q_used,
  output logic               q_push,
  output q_entry_t           q_push_entry
);

  front_state_t state_r, state_nxt;
  idx_t         head_r, head_nxt;
  idx_t         fill_r, fill_nxt;
  idx_t         rd_idx_r, rd_idx_nxt;
  idx_t         dat_idx_r, dat_idx_nxt;
  logic         rd_pend_r, rd_pend_nxt;
  logic [7:0]   prev_r, prev_nxt;
  logic [7:0]   crc_r, crc_nxt;
  logic         ok_r, ok_nxt;

  logic [7:0]   frame_mem [FRAME_BYTES];
  logic [7:0]   mem_q_r;
  logic         mem_we;
  idx_t         wr_addr;
  idx_t         rd_addr;
  logic         issue;
  logic         ok_chk;
  idx_t         hit_off;

  assign wr_addr = wrap_idx({1'b0, head_r} + {1'b0, fill_r});
  assign rd_addr = wrap_idx({1'b0, head_r} + {1'b0, rd_idx_r});
  assign hit_off = dat_idx_r - 7'd1;

  // read issue per sweep; readout keeps one queue slot per read in flight
  always_comb begin
    case (state_r)
      ST_CHECK: issue = (rd_idx_r < FRAME_BYTES);
      ST_SCAN:  issue = (rd_idx_r < FRAME_BYTES);
      ST_EMIT:  issue = (rd_idx_r <= FIELD_END) &&
                        (({1'b0, q_used} + Q_CNT_W'(rd_pend_r)) < (Q_CNT_W + 1)'(Q_DEPTH));
      default:  issue = 1'b0;
    endcase
  end

  // frame checks on the byte coming back from the buffer
  always_comb begin
    ok_chk = ok_r;
    if (dat_idx_r == 7'd0 && mem_q_r != HDR0)        ok_chk = 1'b0;
    if (dat_idx_r == 7'd1 && mem_q_r != HDR1)        ok_chk = 1'b0;
    if (dat_idx_r == LEN_POS && mem_q_r != LEN_VAL)  ok_chk = 1'b0;
    if (dat_idx_r == CRC_POS && mem_q_r != crc_r)    ok_chk = 1'b0;
    if (dat_idx_r == TAIL0_POS && mem_q_r != TAIL0)  ok_chk = 1'b0;
    if (dat_idx_r == FRAME_LAST && mem_q_r != TAIL1) ok_chk = 1'b0;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    prev_nxt     = prev_r;
    crc_nxt      = crc_r;
    ok_nxt       = ok_r;
    rd_idx_nxt   = rd_idx_r;
    dat_idx_nxt  = dat_idx_r;
    rd_pend_nxt  = issue;
    in_tready    = 1'b0;
    mem_we       = 1'b0;
    q_push       = 1'b0;
    q_push_entry = '{data: mem_q_r, tag: field_tag(dat_idx_r)};

    if (issue) begin
      rd_idx_nxt  = rd_idx_r + 7'd1;
      dat_idx_nxt = rd_idx_r;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mem_we   = 1'b1;
          prev_nxt = in_tdata;
          if (fill_r == 7'd0) begin
            fill_nxt = 7'd1;
          end else if (fill_r == 7'd1) begin
            // second byte decides whether a header starts
            if (prev_r == HDR0 && in_tdata == HDR1) begin
              fill_nxt = 7'd2;
            end else begin
              head_nxt = wr_addr;
              fill_nxt = 7'd1;
            end
          end else begin
            fill_nxt = fill_r + 7'd1;
            if (fill_r == FRAME_LAST) begin
              state_nxt   = ST_CHECK;
              rd_idx_nxt  = 7'd0;
              rd_pend_nxt = 1'b0;
              crc_nxt     = 8'd0;
              ok_nxt      = 1'b1;
            end
          end
        end
      end

      ST_CHECK: begin
        if (rd_pend_r) begin
          if (dat_idx_r < CRC_POS) crc_nxt = crc8_byte(crc_r, mem_q_r);
          ok_nxt = ok_chk;
          if (dat_idx_r == FRAME_LAST) begin
            rd_pend_nxt = 1'b0;
            if (ok_chk) begin
              state_nxt  = ST_EMIT;
              fill_nxt   = 7'd0;
              rd_idx_nxt = FIELD_FIRST;
            end else begin
              state_nxt  = ST_SCAN;
              rd_idx_nxt = 7'd1;
            end
          end
        end
      end

      ST_SCAN: begin
        // look for a header from byte 1 on; first byte is dropped
        if (rd_pend_r) begin
          if (dat_idx_r == 7'd1) begin
            prev_nxt = mem_q_r;
          end else if (prev_r == HDR0 && mem_q_r == HDR1) begin
            head_nxt    = wrap_idx({1'b0, head_r} + {1'b0, hit_off});
            fill_nxt    = FRAME_BYTES - hit_off;
            state_nxt   = ST_IDLE;
            rd_pend_nxt = 1'b0;
          end else begin
            prev_nxt = mem_q_r;
            if (dat_idx_r == FRAME_LAST) begin
              // no header: keep the newest byte only
              head_nxt    = wrap_idx({1'b0, head_r} + {1'b0, FRAME_LAST});
              fill_nxt    = 7'd1;
              state_nxt   = ST_IDLE;
              rd_pend_nxt = 1'b0;
            end
          end
        end
      end

      ST_EMIT: begin
        if (rd_pend_r) begin
          q_push = 1'b1;
          if (dat_idx_r == FIELD_END) begin
            state_nxt   = ST_IDLE;
            rd_pend_nxt = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      fill_r    <= '0;
      rd_idx_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      rd_idx_r  <= rd_idx_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dat_idx_r <= dat_idx_nxt;
    prev_r    <= prev_nxt;
    crc_r     <= crc_nxt;
    ok_r      <= ok_nxt;
  end

  // frame buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[wr_addr] <= in_tdata;
    mem_q_r <= frame_mem[rd_addr];
  end

endmodule

// ===== hdl/sfd_back.sv =====
module sfd_back
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  q_entry_t    q_entry,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [63:0] field_value
  output logic [4:0]  out_tuser,   // [4:0] field_id
  output logic        out_tlast    // last_field
);

  logic [55:0] acc_r;
  logic [63:0] merged;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [4:0]  out_fid_r;
  logic        out_last_r;

  // a field's last byte needs the output register free
  assign q_pop = q_valid && (!q_entry.tag.fend || !out_valid_r || out_tready);

  // drop the byte into its lane; lane 0 starts a new field
  always_comb begin
    merged = (q_entry.tag.pos == 3'd0) ? 64'd0 : {8'd0, acc_r};
    merged[{q_entry.tag.pos, 3'b000} +: 8] = q_entry.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && q_entry.tag.fend) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) acc_r <= merged[55:0];
    if (q_pop && q_entry.tag.fend) begin
      out_data_r <= merged;
      out_fid_r  <= q_entry.tag.fid;
      out_last_r <= (q_entry.tag.fid == FID_STATUS);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fid_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/sensor_frame_deframer_crc8.sv =====
// Takes one byte per cycle while a frame fills; the 72nd byte starts a buffer sweep.
// Check sweep reads all 72 buffered bytes and checks header, length, CRC and tail; it is
// followed by readout of bytes 5..68 into the byte queue, or by a rescan for a header.
// Buffer port gives one read a cycle; readout reads hold while the four-entry byte queue is full.
// Synchronous active-low reset clears sequencer, fill count, queue and output valid.
`include "sensor_frame_deframer_crc8_defines.svh"

module sensor_frame_deframer_crc8
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [63:0] field_value
  output logic [4:0]  out_tuser,   // [4:0] field_id
  output logic        out_tlast    // last_field
);

  logic               q_push;
  q_entry_t           q_push_entry;
  logic               q_pop;
  q_entry_t           q_head;
  logic               q_empty;
  logic [Q_CNT_W-1:0] q_used;

  // byte intake, frame buffer, check and readout
  sfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .q_used       (q_used),
    .q_push       (q_push),
    .q_push_entry (q_push_entry)
  );

  sfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head_entry (q_head),
    .empty      (q_empty),
    .used       (q_used)
  );

  // field assembly and output register
  sfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_entry    (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `SFD_ASSERT_NOW(a_q_no_overflow, q_push, q_used != (Q_CNT_W)'(Q_DEPTH), "queue push while full")
  `SFD_ASSERT_NOW(a_no_intake_in_readout, q_push, !in_tready, "byte taken during readout")
  `SFD_ASSERT_NOW(a_last_on_status, out_tvalid, out_tlast == (out_tuser == FID_STATUS), "tlast off status field")
  `SFD_ASSERT_NEXT(a_q_drains_when_free, q_empty && !q_push, q_used == '0, "queue count moved without push")

endmodule
